@@ hw/rtl/ffa_pkg.sv @@
// Shared types and constants for the first-fit heap allocator.
// Used by ffa_hdr_ram, ffa_ctrl and first_fit_heap_allocator; no dependencies.
`timescale 1ns / 1ps

package ffa_pkg;

	localparam int HEAP_WORDS   = 4096;
	localparam int HEADER_WORDS = 3;
	localparam int OFS_W        = $clog2(HEAP_WORDS);
	// one bit more than an offset: holds header + header words + payload size
	localparam int SUM_W        = OFS_W + 1;

	localparam logic [SUM_W-1:0] HEAP_END = SUM_W'(HEAP_WORDS);
	localparam logic [SUM_W-1:0] HDR_X    = SUM_W'(HEADER_WORDS);
	localparam logic [OFS_W-1:0] HDR_N    = OFS_W'(HEADER_WORDS);

	typedef enum logic {
		CMD_ALLOC = 1'b0,
		CMD_FREE  = 1'b1
	} cmd_e;

	localparam logic ST_OK    = 1'b0;
	localparam logic ST_NOFIT = 1'b1;

	// one block header: payload size, previous block's size, used mark
	typedef struct packed {
		logic [OFS_W-1:0] size;
		logic [OFS_W-1:0] prev;
		logic             used;
	} header_t;

	localparam header_t HDR_RESET = '{size: OFS_W'(HEAP_WORDS - HEADER_WORDS),
		prev: '0, used: 1'b0};

	typedef struct packed {
		logic             we;
		logic [OFS_W-1:0] addr;
		header_t          wdata;
	} mem_req_t;

	typedef struct packed {
		logic [OFS_W-1:0] result_addr;
		logic [OFS_W-1:0] granted_size;
		logic             status;
	} result_t;

endpackage

@@ hw/rtl/first_fit_heap_allocator.sv @@
// First-fit heap allocator, top level: stream ports, header RAM and sequencer.
// Depends on ffa_pkg, ffa_hdr_ram and ffa_ctrl.
`timescale 1ns / 1ps

// A word walks the block headers from offset 0, one header read per cycle from
// the single-port header RAM, and a split or merge then rewrites the
// neighbouring headers. There is no clearing pass after reset: the block is
// ready at once. A finished result waits in the output register while the
// next word is accepted.
module first_fit_heap_allocator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // [11:0] request_size, [23:12] block_addr
	input  logic [0:0]  s_tuser,  // [0] cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // [11:0] result_addr, [23:12] granted_size
	output logic [0:0]  m_tuser   // [0] status
);
	import ffa_pkg::*;

	mem_req_t mem_req;
	header_t  rd_hdr;
	result_t  res, out_q;
	logic     res_valid, res_take, out_valid_q;

	ffa_hdr_ram u_ram (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (mem_req),
		.rdata (rd_hdr)
	);

	ffa_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.cmd         (cmd_e'(s_tuser[0])),
		.request_size(s_tdata[11:0]),
		.block_addr  (s_tdata[23:12]),
		.mem_req     (mem_req),
		.rd_hdr      (rd_hdr),
		.res_valid   (res_valid),
		.res         (res),
		.res_take    (res_take)
	);

	// output register
	assign res_take = res_valid && (!out_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_q.granted_size, out_q.result_addr};
	assign m_tuser  = out_q.status;

	// a failed allocate carries no offset and no size
	a_nofit_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0] == ST_NOFIT) |-> (m_tdata == '0))
		else $error("failed allocate with nonzero payload");

	// one word in flight: accepting a word closes the input
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input accepted while busy");

	// a result is handed over only while the sequencer is not taking input
	a_res_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !s_tready)
		else $error("result and input ready together");

endmodule

@@ hw/rtl/ffa_hdr_ram.sv @@
// Single-port header memory, one header per word offset, registered read.
// Depends on ffa_pkg; entry 0 reads as the initial whole-heap block until written.
`timescale 1ns / 1ps

module ffa_hdr_ram (
	input  logic              clk,
	input  logic              arst_n,
	input  ffa_pkg::mem_req_t req,
	output ffa_pkg::header_t  rdata
);
	import ffa_pkg::*;

	header_t mem [HEAP_WORDS];
	header_t rd_q;
	logic    rd_zero_q;
	logic    h0_written_q;

	// storage: write, or registered read
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= req.wdata;
		end else begin
			rd_q <= mem[req.addr];
		end
	end

	// entry 0 stands for the whole heap until its first write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h0_written_q <= 1'b0;
			rd_zero_q    <= 1'b0;
		end else begin
			if (req.we && req.addr == '0) begin
				h0_written_q <= 1'b1;
			end
			if (!req.we) begin
				rd_zero_q <= (req.addr == '0);
			end
		end
	end

	assign rdata = (rd_zero_q && !h0_written_q) ? HDR_RESET : rd_q;

endmodule

@@ hw/rtl/ffa_ctrl.sv @@
// Sequencer: walks the header chain, then splits or merges blocks by
// read-modify-write of the header memory. Depends on ffa_pkg.
`timescale 1ns / 1ps

module ffa_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  ffa_pkg::cmd_e             cmd,
	input  logic [ffa_pkg::OFS_W-1:0] request_size,
	input  logic [ffa_pkg::OFS_W-1:0] block_addr,
	output ffa_pkg::mem_req_t         mem_req,
	input  ffa_pkg::header_t          rd_hdr,
	output logic                      res_valid,
	output ffa_pkg::result_t          res,
	input  logic                      res_take
);
	import ffa_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_WALK, S_ASPLIT, S_FNEXT, S_FBEF, S_FRD, S_FWR, S_DONE
	} state_t;

	state_t           state_q;
	cmd_e             cmd_q;
	logic [OFS_W-1:0] req_q, addr_q, h_q, nh_q, bef_addr_q;
	header_t          cur_q, bef_q;
	logic             has_bef_q;
	logic [SUM_W-1:0] nx_q, fol_q;
	logic [OFS_W-1:0] fol_prev_q, s_new_q;
	result_t          res_q;

	logic [SUM_W-1:0] h_ext, nx, nh, nf;
	logic [OFS_W-1:0] rem, s_new, bsize;
	logic             fit, split, found, merge_n, merge_b;

	// chain arithmetic on the header just read
	always_comb begin
		h_ext   = {1'b0, h_q};
		nx      = h_ext + HDR_X + {1'b0, rd_hdr.size};
		nh      = h_ext + HDR_X + {1'b0, req_q};
		fit     = !rd_hdr.used && (rd_hdr.size >= req_q);
		rem     = rd_hdr.size - req_q;
		split   = (rem >= HDR_N) && (nh < HEAP_END);
		found   = ((h_ext + HDR_X) == {1'b0, addr_q});
		merge_n = (nx_q < HEAP_END) && !rd_hdr.used;
		s_new   = merge_n ? (cur_q.size + rd_hdr.size + HDR_N) : cur_q.size;
		nf      = merge_n ? (nx_q + HDR_X + {1'b0, rd_hdr.size}) : nx_q;
		merge_b = has_bef_q && !bef_q.used;
		bsize   = bef_q.size + s_new_q + HDR_N;
	end

	// memory port: one access per cycle
	always_comb begin
		mem_req = '{we: 1'b0, addr: '0, wdata: rd_hdr};
		case (state_q)
			S_WALK: begin
				if (cmd_q == CMD_ALLOC && fit) begin
					mem_req.we    = 1'b1;
					mem_req.addr  = h_q;
					mem_req.wdata = '{size: (split ? req_q : rd_hdr.size),
						prev: rd_hdr.prev, used: 1'b1};
				end else begin
					mem_req.addr = nx[OFS_W-1:0];
				end
			end
			S_ASPLIT: begin
				mem_req.we    = 1'b1;
				mem_req.addr  = nh_q;
				mem_req.wdata = '{size: fol_prev_q, prev: req_q, used: 1'b0};
			end
			S_FNEXT: begin
				mem_req.we    = 1'b1;
				mem_req.addr  = h_q;
				mem_req.wdata = '{size: s_new, prev: cur_q.prev, used: 1'b0};
			end
			S_FBEF: begin
				mem_req.we    = 1'b1;
				mem_req.addr  = bef_addr_q;
				mem_req.wdata = '{size: bsize, prev: bef_q.prev, used: 1'b0};
			end
			S_FRD: begin
				mem_req.addr = fol_q[OFS_W-1:0];
			end
			S_FWR: begin
				mem_req.we    = 1'b1;
				mem_req.addr  = fol_q[OFS_W-1:0];
				mem_req.wdata = '{size: rd_hdr.size, prev: fol_prev_q, used: rd_hdr.used};
			end
			default: begin
				mem_req.addr = '0;
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cmd_q     <= cmd;
						req_q     <= request_size;
						addr_q    <= block_addr;
						h_q       <= '0;
						has_bef_q <= 1'b0;
						res_q     <= '{result_addr: '0, granted_size: '0, status: ST_OK};
						state_q   <= S_WALK;
					end
				end
				S_WALK: begin
					if (cmd_q == CMD_ALLOC) begin
						if (fit) begin
							res_q <= '{result_addr: (h_q + HDR_N),
								granted_size: (split ? req_q : rd_hdr.size), status: ST_OK};
							nh_q       <= nh[OFS_W-1:0];
							fol_q      <= nx;
							fol_prev_q <= rem - HDR_N;
							state_q    <= split ? S_ASPLIT : S_DONE;
						end else if (nx >= HEAP_END) begin
							res_q.status <= ST_NOFIT;
							state_q      <= S_DONE;
						end else begin
							h_q <= nx[OFS_W-1:0];
						end
					end else begin
						if (found) begin
							cur_q   <= rd_hdr;
							nx_q    <= nx;
							state_q <= rd_hdr.used ? S_FNEXT : S_DONE;
						end else if (nx >= HEAP_END) begin
							state_q <= S_DONE;
						end else begin
							bef_addr_q <= h_q;
							bef_q      <= rd_hdr;
							has_bef_q  <= 1'b1;
							h_q        <= nx[OFS_W-1:0];
						end
					end
				end
				S_ASPLIT: begin
					state_q <= S_FRD;
				end
				S_FNEXT: begin
					s_new_q    <= s_new;
					fol_q      <= nf;
					fol_prev_q <= s_new;
					if (merge_b) begin
						state_q <= S_FBEF;
					end else if (merge_n) begin
						state_q <= S_FRD;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_FBEF: begin
					fol_prev_q <= bsize;
					state_q    <= S_FRD;
				end
				S_FRD: begin
					state_q <= (fol_q < HEAP_END) ? S_FWR : S_DONE;
				end
				S_FWR: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res       = res_q;

endmodule

@@ tb/testbench.sv @@
// Self-checking bench for first_fit_heap_allocator: stream stimulus, heap predictor, scoreboard.
// Depends on ffa_pkg and the allocator RTL only.
`timescale 1ns / 1ps

module testbench;
	import ffa_pkg::*;

	typedef struct {
		cmd_e             cmd;
		logic [11:0]      req;
		logic [11:0]      addr;
		bit               known;
		logic [11:0]      x_addr;
		logic [11:0]      x_size;
		logic             x_status;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;
	logic [0:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic [0:0]  m_tuser;

	// heap image kept by the predictor
	int unsigned blk_size [HEAP_WORDS];
	bit          blk_used [HEAP_WORDS];
	result_t     pending_results [$];
	logic [11:0] live_blocks [$];
	int          fail_count = 0;
	int          words_sent = 0;
	int          words_seen = 0;
	int          nofit_seen = 0;
	int          free_seen = 0;
	bit          hold_sink = 1'b0;
	bit          all_sent = 1'b0;

	first_fit_heap_allocator u_top (.*);

	always #6 clk = ~clk;

	function automatic int unsigned next_hdr(int unsigned h);
		int unsigned n;
		n = h + HEADER_WORDS + blk_size[h];
		return (n >= HEAP_WORDS) ? HEAP_WORDS : n;
	endfunction

	function automatic void heap_clear();
		for (int i = 0; i < HEAP_WORDS; i++) begin
			blk_size[i] = 0;
			blk_used[i] = 1'b0;
		end
		blk_size[0] = HEAP_WORDS - HEADER_WORDS;
	endfunction

	// first-fit grant with split; returns the result word
	function automatic result_t heap_alloc(int unsigned req);
		int unsigned h;
		int unsigned sz;
		int unsigned nh;
		result_t r;
		h = 0;
		r = '{result_addr: '0, granted_size: '0, status: ST_NOFIT};
		while (h < HEAP_WORDS) begin
			if (!blk_used[h] && blk_size[h] >= req) begin
				sz = blk_size[h];
				nh = h + HEADER_WORDS + req;
				if (sz - req >= HEADER_WORDS && nh < HEAP_WORDS) begin
					blk_size[h] = req;
					blk_size[nh] = sz - req - HEADER_WORDS;
					blk_used[nh] = 1'b0;
				end
				blk_used[h] = 1'b1;
				r.result_addr = 12'(h + HEADER_WORDS);
				r.granted_size = 12'(blk_size[h]);
				r.status = ST_OK;
				return r;
			end
			h = next_hdr(h);
		end
		return r;
	endfunction

	// release with merge on both sides; bad offsets are ignored
	function automatic void heap_free(int unsigned addr);
		int unsigned h;
		int unsigned prv;
		int unsigned n;
		bit has_prv;
		bit hit;
		h = 0; prv = 0; has_prv = 0; hit = 0;
		while (1) begin
			if (h + HEADER_WORDS == addr) begin
				hit = 1;
				break;
			end
			n = next_hdr(h);
			if (n >= HEAP_WORDS) break;
			prv = h; has_prv = 1; h = n;
		end
		if (!hit || !blk_used[h]) return;
		blk_used[h] = 1'b0;
		n = next_hdr(h);
		if (n < HEAP_WORDS && !blk_used[n])
			blk_size[h] += blk_size[n] + HEADER_WORDS;
		if (has_prv && !blk_used[prv])
			blk_size[prv] += blk_size[h] + HEADER_WORDS;
	endfunction

	function automatic result_t predict_word(cmd_e cmd, logic [11:0] req, logic [11:0] addr);
		if (cmd == CMD_ALLOC) return heap_alloc(req);
		heap_free(addr);
		return '{result_addr: '0, granted_size: '0, status: ST_OK};
	endfunction

	task automatic send_word(cmd_e cmd, logic [11:0] req, logic [11:0] addr);
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {addr, req};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		words_sent++;
	endtask

	task automatic source_gap();
		int g;
		g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
		if ($urandom_range(0, 3) == 0) g = 0;
		if (g > 0) begin
			s_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	// issue one word, keeping the prediction and the live list in step
	task automatic issue(cmd_e cmd, logic [11:0] req, logic [11:0] addr, bit known = 0,
			result_t want = '0);
		result_t r;
		int idx;
		r = predict_word(cmd, req, addr);
		if (known && r != want) begin
			$error("directed row: expected %h, predictor gives %h", want, r);
			fail_count++;
		end
		if (cmd == CMD_ALLOC && r.status == ST_OK) live_blocks.push_back(r.result_addr);
		if (cmd == CMD_FREE) begin
			idx = -1;
			foreach (live_blocks[i]) if (live_blocks[i] == addr) idx = i;
			if (idx >= 0) live_blocks.delete(idx);
		end
		pending_results.push_back(r);
		send_word(cmd, req, addr);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	// result checker
	always @(posedge clk) begin
		result_t exp_r;
		if (m_tvalid && m_tready) begin
			words_seen++;
			if (pending_results.size() == 0) begin
				$error("result word with nothing expected");
				fail_count++;
			end else begin
				exp_r = pending_results.pop_front();
				if (m_tdata[11:0] !== exp_r.result_addr) begin
					$error("result_addr: expected %0d, got %0d", exp_r.result_addr, m_tdata[11:0]);
					fail_count++;
				end
				if (m_tdata[23:12] !== exp_r.granted_size) begin
					$error("granted_size: expected %0d, got %0d", exp_r.granted_size,
						m_tdata[23:12]);
					fail_count++;
				end
				if (m_tuser[0] !== exp_r.status) begin
					$error("status: expected %0d, got %0d", exp_r.status, m_tuser[0]);
					fail_count++;
				end
				if (exp_r.status == ST_NOFIT) nofit_seen++;
			end
		end
	end

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		int g;
		@(posedge arst_n);
		forever begin
			if (hold_sink) begin
				m_tready <= 1'b0;
				repeat (400) @(posedge clk);
				hold_sink = 1'b0;
			end
			g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
			if ($urandom_range(0, 3) == 0 || all_sent) g = 0;
			if (g > 0) begin
				m_tready <= 1'b0;
				repeat (g) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
		end
	end

	initial begin
		#100_000_000;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		row_t rows [$];
		int n;
		int pick;
		heap_clear();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: fresh heap, extremes, no-fit, bad frees, merges
		rows.push_back('{CMD_ALLOC, 12'd0, 12'd0, 1, 12'd3, 12'd0, ST_OK});
		rows.push_back('{CMD_ALLOC, 12'd4093, 12'd0, 1, 12'd0, 12'd0, ST_NOFIT});
		rows.push_back('{CMD_ALLOC, 12'd10, 12'd0, 1, 12'd6, 12'd10, ST_OK});
		rows.push_back('{CMD_ALLOC, 12'd1, 12'd0, 0, 0, 0, 0});
		rows.push_back('{CMD_FREE, 12'd0, 12'd4095, 1, 12'd0, 12'd0, ST_OK});
		rows.push_back('{CMD_FREE, 12'd4095, 12'd0, 1, 12'd0, 12'd0, ST_OK});
		rows.push_back('{CMD_FREE, 12'd0, 12'd6, 1, 12'd0, 12'd0, ST_OK});
		rows.push_back('{CMD_FREE, 12'd0, 12'd6, 1, 12'd0, 12'd0, ST_OK});
		rows.push_back('{CMD_FREE, 12'd0, 12'd3, 0, 0, 0, 0});
		rows.push_back('{CMD_ALLOC, 12'd2, 12'd0, 0, 0, 0, 0});
		rows.push_back('{CMD_ALLOC, 12'd4000, 12'd0, 0, 0, 0, 0});
		rows.push_back('{CMD_ALLOC, 12'd200, 12'd0, 0, 0, 0, 0});
		rows.push_back('{CMD_FREE, 12'd0, 12'd3, 0, 0, 0, 0});
		rows.push_back('{CMD_ALLOC, 12'd0, 12'd0, 0, 0, 0, 0});
		rows.push_back('{CMD_ALLOC, 12'd4093, 12'd0, 0, 0, 0, 0});
		foreach (rows[i])
			issue(rows[i].cmd, rows[i].req, rows[i].addr, rows[i].known,
				'{result_addr: rows[i].x_addr, granted_size: rows[i].x_size,
				status: rows[i].x_status});
		drain();
		// free everything, then the whole heap in one grant
		while (live_blocks.size() != 0) issue(CMD_FREE, 12'd0, live_blocks[0]);
		issue(CMD_ALLOC, 12'd4093, 12'd0, 1, '{12'd3, 12'd4093, ST_OK});
		issue(CMD_FREE, 12'd0, 12'd3);

		// random: mostly valid alloc/free traffic, some junk frees
		n = 0;
		while (n < 1100) begin
			pick = $urandom_range(0, 99);
			if (n == 300) hold_sink = 1'b1;
			if (n == 600) drain();
			if (pick < 50 || live_blocks.size() == 0) begin
				if ($urandom_range(0, 19) == 0)
					issue(CMD_ALLOC, 12'($urandom_range(0, 4095)), 12'($urandom()));
				else
					issue(CMD_ALLOC, 12'($urandom_range(0, 120)), 12'($urandom()));
			end else if (pick < 92) begin
				issue(CMD_FREE, 12'($urandom()),
					live_blocks[$urandom_range(0, live_blocks.size() - 1)]);
				free_seen++;
			end else begin
				issue(CMD_FREE, 12'($urandom()), 12'($urandom()));
			end
			source_gap();
			n++;
		end
		all_sent = 1'b1;
		drain();
		repeat (200) @(posedge clk);
		$display("Covered %0d words in, %0d results checked (%0d no-fit, %0d valid frees).",
			words_sent, words_seen, nofit_seen, free_seen);
		if (fail_count == 0 && pending_results.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
